[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never hold on a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[rtl/core/x86alu_pkg.sv]
// Constants, types and helpers of the 8086-style execute unit.
package x86alu_pkg;

	localparam int ADDR_BITS    = 16;
	localparam int BANK_BITS    = ADDR_BITS - 1;
	localparam int BANK_DEPTH   = 2 ** BANK_BITS;
	localparam int REG_COUNT    = 8;
	localparam int REG_IDX_BITS = 3;

	typedef logic [2:0]              action_t;
	typedef logic [1:0]              src_kind_t;
	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
	typedef logic [ADDR_BITS-1:0]    maddr_t;
	typedef logic [BANK_BITS-1:0]    bank_idx_t;

	localparam action_t ACT_MOV = 3'd0;
	localparam action_t ACT_ADD = 3'd1;
	localparam action_t ACT_AND = 3'd2;
	localparam action_t ACT_OR  = 3'd3;
	localparam action_t ACT_XOR = 3'd4;
	localparam action_t ACT_NOT = 3'd5;

	localparam src_kind_t SRC_IMM = 2'd0;
	localparam src_kind_t SRC_REG = 2'd1;
	localparam src_kind_t SRC_MEM = 2'd2;

	localparam reg_idx_t    SP_CODE  = 3'd4;
	localparam logic [15:0] SP_RESET = 16'hFFFE;

	// Value a register holds before its first write.
	function automatic logic [15:0] reg_reset_value(input reg_idx_t idx);
		return (idx == SP_CODE) ? SP_RESET : 16'h0000;
	endfunction

	// Register file row behind a register code: byte codes 4..7 map to the high half of 0..3.
	function automatic reg_idx_t reg_row(input reg_idx_t code, input logic word);
		return word ? code : {1'b0, code[REG_IDX_BITS-2:0]};
	endfunction

endpackage

[rtl/core/x86alu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module x86alu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/x86_logic_alu_regmem_execute.sv]
// Execute unit for 8086-style MOV/ADD/AND/OR/XOR/NOT at byte or word size. On the accept edge
// the register file and both data-memory byte banks are read, and on the next edge at which the
// output register is free the result is written back and loaded into the output register. The
// input stalls while an item sits between read and write-back, so no new item is taken until
// the last one is written back, and the next item's reads already see that write with no
// forwarding. A finished result waits in the output register without blocking the next accept;
// while that beat is not taken, the item behind it holds its write-back and the input stays
// stalled. Data memory is two byte banks (even and odd addresses) so a word read or write
// touches both bytes in the same access; memory needs no clearing pass, and the register file
// resets at once through per-row valid bits.
`include "assert_macros.svh"

module x86_logic_alu_regmem_execute
	import x86alu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic        is_word,
	input  logic        dest_in_memory,
	input  logic [1:0]  source_kind,
	input  logic [2:0]  dest_reg,
	input  logic [2:0]  src_reg,
	input  logic [15:0] address,
	input  logic [15:0] immediate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] written_value,
	output logic        bad_combination
);

	// accept side
	logic      in_acc;
	maddr_t    in_a, in_a1;
	reg_idx_t  in_src_row, in_dst_row;
	bank_idx_t in_even_idx, in_odd_idx;

	// stage 1
	logic        v_s1;
	action_t     action_s1;
	logic        word_s1, dmem_s1;
	src_kind_t   skind_s1;
	reg_idx_t    dreg_s1, sreg_s1;
	maddr_t      addr_s1;
	logic [15:0] imm_s1;
	logic        src_vld_s1, dst_vld_s1;

	logic [REG_COUNT-1:0] reg_vld_q;
	logic [15:0] rf_src_rdata, rf_dst_rdata;
	logic [7:0]  even_rdata, odd_rdata;

	logic        done_s1, write_ok, bad;
	maddr_t      a1_s1;
	bank_idx_t   even_idx_s1, odd_idx_s1;
	reg_idx_t    src_row_s1, dst_row_s1;
	logic [15:0] src_full, dst_full, mem_val, reg_dst, src_op, dst_op, res, res_m;
	logic        rf_we, even_we, odd_we;
	logic [15:0] rf_wdata;
	logic [7:0]  even_wdata, odd_wdata;

	logic        out_v_q;
	logic [15:0] wval_q;
	logic        bad_q;

	assign in_stall = v_s1;
	assign in_acc   = in_valid && !in_stall;

	// the high byte of a word sits in the other bank; the even bank takes the wrapped address
	assign in_a        = ADDR_BITS'(address);
	assign in_a1       = in_a + maddr_t'(1);
	assign in_odd_idx  = in_a[ADDR_BITS-1:1];
	assign in_even_idx = in_a[0] ? in_a1[ADDR_BITS-1:1] : in_a[ADDR_BITS-1:1];
	assign in_src_row  = reg_row(src_reg, is_word);
	assign in_dst_row  = reg_row(dest_reg, is_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (done_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1  <= action;
			word_s1    <= is_word;
			dmem_s1    <= dest_in_memory;
			skind_s1   <= source_kind;
			dreg_s1    <= dest_reg;
			sreg_s1    <= src_reg;
			addr_s1    <= in_a;
			imm_s1     <= immediate;
			src_vld_s1 <= reg_vld_q[in_src_row];
			dst_vld_s1 <= reg_vld_q[in_dst_row];
		end
	end

	x86alu_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_src (
		.clk   (clk),
		.we    (rf_we),
		.waddr (dst_row_s1),
		.wdata (rf_wdata),
		.re    (in_acc),
		.raddr (in_src_row),
		.rdata (rf_src_rdata)
	);

	x86alu_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_dst (
		.clk   (clk),
		.we    (rf_we),
		.waddr (dst_row_s1),
		.wdata (rf_wdata),
		.re    (in_acc),
		.raddr (in_dst_row),
		.rdata (rf_dst_rdata)
	);

	x86alu_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_even (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_idx_s1),
		.wdata (even_wdata),
		.re    (in_acc),
		.raddr (in_even_idx),
		.rdata (even_rdata)
	);

	x86alu_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_odd (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_idx_s1),
		.wdata (odd_wdata),
		.re    (in_acc),
		.raddr (in_odd_idx),
		.rdata (odd_rdata)
	);

	always_comb begin
		a1_s1       = addr_s1 + maddr_t'(1);
		odd_idx_s1  = addr_s1[ADDR_BITS-1:1];
		even_idx_s1 = addr_s1[0] ? a1_s1[ADDR_BITS-1:1] : addr_s1[ADDR_BITS-1:1];
		src_row_s1  = reg_row(sreg_s1, word_s1);
		dst_row_s1  = reg_row(dreg_s1, word_s1);

		// rows never written read as their reset value
		src_full = src_vld_s1 ? rf_src_rdata : reg_reset_value(src_row_s1);
		dst_full = dst_vld_s1 ? rf_dst_rdata : reg_reset_value(dst_row_s1);

		mem_val = addr_s1[0] ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
		if (!word_s1) begin
			mem_val[15:8] = 8'h00;
		end

		reg_dst = word_s1 ? dst_full
			: {8'h00, (dreg_s1[REG_IDX_BITS-1] ? dst_full[15:8] : dst_full[7:0])};

		unique case (skind_s1)
			SRC_REG: src_op = word_s1 ? src_full
				: {8'h00, (sreg_s1[REG_IDX_BITS-1] ? src_full[15:8] : src_full[7:0])};
			SRC_MEM: src_op = mem_val;
			default: src_op = word_s1 ? imm_s1 : {8'h00, imm_s1[7:0]};
		endcase

		dst_op = dmem_s1 ? mem_val : reg_dst;

		unique case (action_s1)
			ACT_MOV: res = src_op;
			ACT_ADD: res = dst_op + src_op;
			ACT_AND: res = dst_op & src_op;
			ACT_OR:  res = dst_op | src_op;
			ACT_XOR: res = dst_op ^ src_op;
			default: res = ~dst_op;
		endcase
		res_m = word_s1 ? res : {8'h00, res[7:0]};

		bad      = (action_s1 <= ACT_XOR) && dmem_s1 && (skind_s1 == SRC_MEM);
		write_ok = (action_s1 <= ACT_NOT) && !bad;
		done_s1  = v_s1 && (!out_v_q || !out_stall);

		// merge a byte result into its half of the destination row
		if (word_s1) begin
			rf_wdata = res_m;
		end else if (dreg_s1[REG_IDX_BITS-1]) begin
			rf_wdata = {res_m[7:0], dst_full[7:0]};
		end else begin
			rf_wdata = {dst_full[15:8], res_m[7:0]};
		end

		rf_we      = done_s1 && write_ok && !dmem_s1;
		even_we    = done_s1 && write_ok && dmem_s1 && (word_s1 || !addr_s1[0]);
		odd_we     = done_s1 && write_ok && dmem_s1 && (word_s1 || addr_s1[0]);
		even_wdata = addr_s1[0] ? res_m[15:8] : res_m[7:0];
		odd_wdata  = addr_s1[0] ? res_m[7:0] : res_m[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q <= '0;
		end else if (rf_we) begin
			reg_vld_q[dst_row_s1] <= 1'b1;
		end
	end

	// output register: load on completion, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (done_s1) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			wval_q <= write_ok ? res_m : 16'h0000;
			bad_q  <= bad;
		end
	end

	assign out_valid       = out_v_q;
	assign written_value   = wval_q;
	assign bad_combination = bad_q;

	`ASSERT_CLK(a_accept_then_busy, in_acc |=> in_stall, "accept not followed by a busy cycle")
	`ASSERT_NEVER(a_write_outside_done, (rf_we || even_we || odd_we) && !(done_s1 && !bad), "stray write")
	`ASSERT_CLK(a_done_shows_beat, done_s1 |=> out_valid, "completed item not presented")

endmodule
